FILE: hdl/ioe_pkg.sv
// ----------------------------------------------------------------------------
// ioe_pkg: shared types and constants of the serial I/O expander shifter
// Transaction payloads, configuration record, register indexes and helpers.
// ----------------------------------------------------------------------------
package ioe_pkg;

  // Chain limits and word sizes
  localparam int MAX_BYTES   = 7;
  localparam int WORD_W      = MAX_BYTES * 8;
  localparam int BYTE_IDX_W  = 3;
  localparam int WAIT_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_BYTES    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_TICKS  = 2'd3;

  // Register reset values
  localparam logic [BYTE_IDX_W-1:0] OUT_BYTES_RST   = 3'd1;
  localparam logic [BYTE_IDX_W-1:0] IN_BYTES_RST    = 3'd0;
  localparam logic [WAIT_W-1:0]     DELAY_TICKS_RST = 8'd0;
  localparam logic [WAIT_W-1:0]     LOAD_TICKS_RST  = 8'd5;

  typedef struct packed {
    logic [BYTE_IDX_W-1:0] out_bytes;
    logic [BYTE_IDX_W-1:0] in_bytes;
    logic [WAIT_W-1:0]     delay_ticks;
    logic [WAIT_W-1:0]     load_ticks;
  } cfg_t;

  typedef struct packed {
    logic              start_req;
    logic [WORD_W-1:0] out_pins;
    logic              serial_in;
  } item_t;

  typedef struct packed {
    logic              shift_clk;
    logic              serial_out;
    logic              latch;
    logic              load;
    logic              busy_res;
    logic              in_valid;
    logic [WORD_W-1:0] in_pins;
  } res_t;

  // Saturate a byte count to the chain length
  function automatic logic [BYTE_IDX_W-1:0] clamp_bytes(input logic [BYTE_IDX_W-1:0] n);
    return (n > BYTE_IDX_W'(MAX_BYTES)) ? BYTE_IDX_W'(MAX_BYTES) : n;
  endfunction

  // Mask covering the lowest n bytes of a pin word
  function automatic logic [WORD_W-1:0] byte_mask(input logic [BYTE_IDX_W-1:0] n);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int k = 0; k < MAX_BYTES; k++) begin
      if (BYTE_IDX_W'(k) < clamp_bytes(n)) begin
        m[8*k +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

FILE: hdl/serial_io_expander_shifter_top.sv
// ----------------------------------------------------------------------------
// serial_io_expander_shifter_top: serial I/O expander shifter
// Tick-driven waveform generator for chained serial output and input expanders.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction (in_valid/in_stall) is one timing tick carrying
//   start_req, the output pin word and the serial input level. Each tick
//   yields exactly one output transaction (out_valid/out_stall) with the pin
//   levels after that tick, busy state, a one-tick in_valid pulse when a
//   refresh finishes and the last sampled input pin word.
//   The cfg_ port writes chain lengths and delays; write only while idle.
//   Path: an accepted tick goes through the input register, then the result
//   register fed by the sequencer's next-state logic, which drives out_valid.
//   Throughput: one tick per cycle unless out_stall holds the result register.
//   A stalled output holds its transaction; the input register keeps one
//   tick, after which in_stall rises until the output drains.
//   Reset (synchronous, rst_n low) empties both registers, holds in_stall
//   high, restores the register defaults and leaves clock, latch and load
//   high, data low.
// ----------------------------------------------------------------------------
module serial_io_expander_shifter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [ioe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ioe_pkg::CFG_DATA_W-1:0] cfg_data,
  // tick input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_start_req,
  input  logic [ioe_pkg::WORD_W-1:0]     in_out_pins,
  input  logic                          in_serial_in,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_shift_clk,
  output logic                          out_serial_out,
  output logic                          out_latch,
  output logic                          out_load,
  output logic                          out_busy_res,
  output logic                          out_in_valid,
  output logic [ioe_pkg::WORD_W-1:0]     out_in_pins
);
  import ioe_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  item_t s1_item;
  res_t  res;
  res_t  out_res_r;
  logic  s1_valid;
  logic  adv;
  logic  out_valid_r;

  assign in_item.start_req = in_start_req;
  assign in_item.out_pins  = in_out_pins;
  assign in_item.serial_in = in_serial_in;

  // Move a tick forward when the result register is free
  assign adv = s1_valid && (!out_valid_r || !out_stall);

  ioe_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ioe_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  ioe_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (s1_item),
    .cfg   (cfg),
    .res   (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_shift_clk  = out_res_r.shift_clk;
  assign out_serial_out = out_res_r.serial_out;
  assign out_latch      = out_res_r.latch;
  assign out_load       = out_res_r.load;
  assign out_busy_res   = out_res_r.busy_res;
  assign out_in_valid   = out_res_r.in_valid;
  assign out_in_pins    = out_res_r.in_pins;

`ifndef SYNTH
  // Finishing tick releases latch and clock and clears busy
  a_finish_pins: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.in_valid) |->
      (out_res_r.latch && out_res_r.shift_clk && !out_res_r.busy_res))
    else $error("top: bad pin levels on finishing tick");

  // Load line only goes low inside a refresh
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.load) |-> out_res_r.busy_res)
    else $error("top: load low while not busy");
`endif

endmodule

FILE: hdl/ioe_cfg_regs.sv
// ----------------------------------------------------------------------------
// ioe_cfg_regs: configuration registers
// Plain write port into the four chain and timing registers.
// ----------------------------------------------------------------------------
module ioe_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ioe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ioe_pkg::CFG_DATA_W-1:0] cfg_data,
  output ioe_pkg::cfg_t                 cfg
);
  import ioe_pkg::*;

  cfg_t cfg_r;

  // Register writes, reset to the documented defaults
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.out_bytes   <= OUT_BYTES_RST;
      cfg_r.in_bytes    <= IN_BYTES_RST;
      cfg_r.delay_ticks <= DELAY_TICKS_RST;
      cfg_r.load_ticks  <= LOAD_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OUT_BYTES:   cfg_r.out_bytes   <= cfg_data[BYTE_IDX_W-1:0];
        CFG_IN_BYTES:    cfg_r.in_bytes    <= cfg_data[BYTE_IDX_W-1:0];
        CFG_DELAY_TICKS: cfg_r.delay_ticks <= cfg_data[WAIT_W-1:0];
        CFG_LOAD_TICKS:  cfg_r.load_ticks  <= cfg_data[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hdl/ioe_in_reg.sv
// ----------------------------------------------------------------------------
// ioe_in_reg: input register
// Holds one tick transaction until the sequencer consumes it.
// ----------------------------------------------------------------------------
module ioe_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ioe_pkg::item_t in_item,
  input  logic           adv,
  output logic           s1_valid,
  output ioe_pkg::item_t s1_item
);
  import ioe_pkg::*;

  logic  s1_valid_r;
  item_t s1_item_r;

  // Free when empty or being drained this cycle; held off during reset
  assign in_stall = !rst_n || (s1_valid_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

FILE: hdl/ioe_seq.sv
// ----------------------------------------------------------------------------
// ioe_seq: refresh sequencer
// Advances the expander waveform by one tick per consumed transaction.
// ----------------------------------------------------------------------------
module ioe_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  ioe_pkg::item_t item,
  input  ioe_pkg::cfg_t  cfg,
  output ioe_pkg::res_t  res
);
  import ioe_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LOAD = 3'd1;
  localparam logic [2:0] PH_PRE  = 3'd2;
  localparam logic [2:0] PH_HIGH = 3'd3;
  localparam logic [2:0] PH_END  = 3'd4;

  localparam logic [2:0] BIT_LAST = 3'd7;

  logic [2:0]            phase_r,    phase_nxt;
  logic [WORD_W-1:0]     out_word_r, out_word_nxt;
  logic [WORD_W-1:0]     in_word_r,  in_word_nxt;
  logic [WORD_W-1:0]     last_in_r,  last_in_nxt;
  logic [BYTE_IDX_W-1:0] byte_r,     byte_nxt;
  logic [2:0]            bit_r,      bit_nxt;
  logic [WAIT_W-1:0]     wait_r,     wait_nxt;
  logic                  clk_r,      clk_nxt;
  logic                  data_r,     data_nxt;
  logic                  latch_r,    latch_nxt;
  logic                  load_r,     load_nxt;
  logic                  done;

  logic [BYTE_IDX_W-1:0] ob, ib, nb;
  logic [5:0]            pos;

  assign ob  = clamp_bytes(cfg.out_bytes);
  assign ib  = clamp_bytes(cfg.in_bytes);
  assign nb  = (ob > ib) ? ob : ib;
  assign pos = {byte_r, bit_r};

  // Next state for one tick
  always_comb begin
    phase_nxt    = phase_r;
    out_word_nxt = out_word_r;
    in_word_nxt  = in_word_r;
    last_in_nxt  = last_in_r;
    byte_nxt     = byte_r;
    bit_nxt      = bit_r;
    wait_nxt     = wait_r;
    clk_nxt      = clk_r;
    data_nxt     = data_r;
    latch_nxt    = latch_r;
    load_nxt     = load_r;
    done         = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (item.start_req) begin
          out_word_nxt = item.out_pins & byte_mask(ob);
          in_word_nxt  = '0;
          byte_nxt     = (nb != '0) ? nb - 1'b1 : '0;
          bit_nxt      = BIT_LAST;
          if (ib != '0) begin
            load_nxt  = 1'b0;
            wait_nxt  = cfg.load_ticks;
            phase_nxt = PH_LOAD;
          end else begin
            latch_nxt = 1'b0;
            wait_nxt  = cfg.delay_ticks;
            phase_nxt = (nb != '0) ? PH_PRE : PH_END;
          end
        end
      end
      PH_LOAD: begin
        if (wait_r != '0) begin
          wait_nxt = wait_r - 1'b1;
        end else begin
          load_nxt  = 1'b1;
          latch_nxt = 1'b0;
          wait_nxt  = cfg.delay_ticks;
          phase_nxt = PH_PRE;
        end
      end
      PH_PRE: begin
        if (wait_r != '0) begin
          wait_nxt = wait_r - 1'b1;
        end else begin
          // clock low: drive data and sample the input chain
          clk_nxt = 1'b0;
          if (ob != '0) begin
            data_nxt = out_word_r[pos];
          end
          if (ib != '0) begin
            in_word_nxt[pos] = item.serial_in;
          end
          phase_nxt = PH_HIGH;
        end
      end
      PH_HIGH: begin
        clk_nxt  = 1'b1;
        wait_nxt = cfg.delay_ticks;
        if (bit_r != '0) begin
          bit_nxt   = bit_r - 1'b1;
          phase_nxt = PH_PRE;
        end else if (byte_r != '0) begin
          byte_nxt  = byte_r - 1'b1;
          bit_nxt   = BIT_LAST;
          phase_nxt = PH_PRE;
        end else begin
          phase_nxt = PH_END;
        end
      end
      PH_END: begin
        if (wait_r != '0) begin
          wait_nxt = wait_r - 1'b1;
        end else begin
          last_in_nxt = in_word_r & byte_mask(ib);
          latch_nxt   = 1'b1;
          clk_nxt     = 1'b1;
          done        = 1'b1;
          phase_nxt   = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // State update on each consumed tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      out_word_r <= '0;
      in_word_r  <= '0;
      last_in_r  <= '0;
      byte_r     <= '0;
      bit_r      <= '0;
      wait_r     <= '0;
      clk_r      <= 1'b1;
      data_r     <= 1'b0;
      latch_r    <= 1'b1;
      load_r     <= 1'b1;
    end else if (step) begin
      phase_r    <= phase_nxt;
      out_word_r <= out_word_nxt;
      in_word_r  <= in_word_nxt;
      last_in_r  <= last_in_nxt;
      byte_r     <= byte_nxt;
      bit_r      <= bit_nxt;
      wait_r     <= wait_nxt;
      clk_r      <= clk_nxt;
      data_r     <= data_nxt;
      latch_r    <= latch_nxt;
      load_r     <= load_nxt;
    end
  end

  // Result of this tick: pin levels after the update
  always_comb begin
    res.shift_clk  = clk_nxt;
    res.serial_out = data_nxt;
    res.latch      = latch_nxt;
    res.load       = load_nxt;
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.in_valid   = done;
    res.in_pins    = last_in_nxt;
  end

`ifndef SYNTH
  // Idle always leaves clock, latch and load released
  a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (clk_r && latch_r && load_r))
    else $error("ioe_seq: pins not released while idle");

  // The high phase always follows a clock low edge
  a_high_clk_low: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HIGH) |-> !clk_r)
    else $error("ioe_seq: clock not low entering high phase");

  // Latch is held low throughout the shifting phases
  a_shift_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PRE || phase_r == PH_HIGH || phase_r == PH_END) |-> !latch_r)
    else $error("ioe_seq: latch high during shifting");
`endif

endmodule
